@@ rtl/core/offset_to_line_lookup_unit_macros.svh @@
// assertion macros for the offset to line lookup unit
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef OFFSET_TO_LINE_LOOKUP_UNIT_MACROS_SVH
`define OFFSET_TO_LINE_LOOKUP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define OLL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// antecedent implies consequent in the next cycle
`define OLL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OLL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define OLL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/oll_pkg.sv @@
// shared types and constants of the offset to line lookup unit
// no dependencies
package oll_pkg;

	localparam int unsigned OLL_MAX_LINES = 1024;
	localparam int unsigned OFS_W         = 32;
	localparam int unsigned LN_W          = 11;

	typedef enum logic {
		CMD_APPEND = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_BELOW = 2'd2,
		ST_ORDER = 2'd3
	} status_t;

	// what the back end has to do with a queued item
	typedef enum logic [1:0] {
		K_RESULT = 2'd0,
		K_WRITE  = 2'd1,
		K_SEARCH = 2'd2
	} kind_t;

	typedef enum logic {
		B_IDLE,
		B_SEARCH
	} back_state_t;

	typedef struct packed {
		kind_t              kind;
		status_t            status;
		logic [OFS_W-1:0]   value;
	} op_t;

	typedef struct packed {
		logic [LN_W-1:0]    line_number;
		logic [OFS_W-1:0]   line_start;
		logic [OFS_W-1:0]   rel_offset;
		status_t            status;
	} res_t;

endpackage

@@ rtl/core/oll_front.sv @@
// front end: takes input transfers, checks them against the table state and queues work
// depends on oll_pkg
module oll_front #(
	parameter int unsigned MAX_LINES = oll_pkg::OLL_MAX_LINES,
	localparam int unsigned IDX_W = $clog2(MAX_LINES)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     cmd,
	input  logic [oll_pkg::OFS_W-1:0] offset,
	input  logic                     cfg_we,
	input  logic [oll_pkg::OFS_W-1:0] cfg_wdata,
	input  logic                     q_full,
	output logic                     q_push,
	output oll_pkg::op_t             q_data,
	output logic [IDX_W-1:0]         q_idx
);
	import oll_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_LINES + 1);

	logic [CNT_W-1:0] count_q;
	logic [OFS_W-1:0] last_q;
	logic [OFS_W-1:0] base_q;
	logic [CNT_W-1:0] count_m1;
	logic             grow;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;
	assign count_m1 = count_q - CNT_W'(1);

	always_comb begin
		q_data.kind   = K_RESULT;
		q_data.status = ST_OK;
		q_data.value  = '0;
		q_idx         = count_m1[IDX_W-1:0];
		grow          = 1'b0;
		if (cmd == CMD_LOOKUP) begin
			if (offset < base_q) begin
				q_data.status = ST_BELOW;
			end else begin
				q_data.kind  = K_SEARCH;
				q_data.value = offset - base_q;
			end
		end else begin
			if (count_q == CNT_W'(MAX_LINES)) begin
				q_data.status = ST_FULL;
			end else if (offset <= last_q) begin
				q_data.status = ST_ORDER;
			end else begin
				q_data.kind  = K_WRITE;
				q_data.value = offset;
				q_idx        = count_q[IDX_W-1:0];
				grow         = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
			last_q  <= '0;
			base_q  <= '0;
		end else begin
			if (q_push && grow) begin
				count_q <= count_q + CNT_W'(1);
				last_q  <= offset;
			end
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
		end
	end

endmodule

@@ rtl/core/oll_queue.sv @@
// two entry queue between front and back end
// depends on oll_pkg
module oll_queue #(
	parameter int unsigned IDX_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  oll_pkg::op_t     data_in,
	input  logic [IDX_W-1:0] idx_in,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output oll_pkg::op_t     data_out,
	output logic [IDX_W-1:0] idx_out
);
	import oll_pkg::*;

	op_t              data_q [2];
	logic [IDX_W-1:0] idx_q  [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign data_out = data_q[rd_ptr_q];
	assign idx_out  = idx_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			data_q[wr_ptr_q] <= data_in;
			idx_q[wr_ptr_q]  <= idx_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

endmodule

@@ rtl/core/oll_back.sv @@
// back end: line start memory, binary search sequencer and output register
// depends on oll_pkg
module oll_back #(
	parameter int unsigned MAX_LINES = oll_pkg::OLL_MAX_LINES,
	localparam int unsigned IDX_W = $clog2(MAX_LINES)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  oll_pkg::op_t              q_data,
	input  logic [IDX_W-1:0]          q_idx,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [oll_pkg::LN_W-1:0]  line_number,
	output logic [oll_pkg::OFS_W-1:0] line_start,
	output logic [oll_pkg::OFS_W-1:0] rel_offset,
	output logic [1:0]                status
);
	import oll_pkg::*;

	// entry zero is never written or read; line 1 has the constant start 0
	logic [OFS_W-1:0] mem [MAX_LINES];

	back_state_t      st_q, st_d;
	logic [IDX_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
	logic [OFS_W-1:0] lo_val_q, lo_val_d, rel_q, rel_d;
	logic [OFS_W-1:0] rd_data_q;
	logic             pend_q, pend_d;
	logic             rd_en, wr_en;
	logic [IDX_W-1:0] s_lo, s_hi;
	logic [OFS_W-1:0] s_lo_val;
	logic             ovalid_q, out_free, load;
	res_t             res_q, res_d;

	function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] lo,
			input logic [IDX_W-1:0] hi);
		logic [IDX_W:0] span;
		span = {1'b0, hi} - {1'b0, lo} + (IDX_W+1)'(1);
		return lo + span[IDX_W:1];
	endfunction

	function automatic logic [LN_W-1:0] line_of(input logic [IDX_W-1:0] i);
		logic [31:0] t;
		t = 32'(i) + 32'd1;
		return t[LN_W-1:0];
	endfunction

	assign out_free    = !ovalid_q || out_ready;
	assign out_valid   = ovalid_q;
	assign line_number = res_q.line_number;
	assign line_start  = res_q.line_start;
	assign rel_offset  = res_q.rel_offset;
	assign status      = res_q.status;

	// one halving step on the data that came back from the memory
	always_comb begin
		s_lo     = lo_q;
		s_hi     = hi_q;
		s_lo_val = lo_val_q;
		if (pend_q) begin
			if (rd_data_q <= rel_q) begin
				s_lo     = mid_q;
				s_lo_val = rd_data_q;
			end else begin
				s_hi = mid_q - IDX_W'(1);
			end
		end
	end

	always_comb begin
		st_d     = st_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		lo_val_d = lo_val_q;
		rel_d    = rel_q;
		mid_d    = mid_q;
		pend_d   = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		q_pop    = 1'b0;
		load     = 1'b0;
		res_d    = res_q;
		unique case (st_q)
			B_IDLE: begin
				if (!q_empty) begin
					unique case (q_data.kind)
						K_WRITE: begin
							if (out_free) begin
								q_pop = 1'b1;
								wr_en = 1'b1;
								load  = 1'b1;
								res_d = '{line_number: line_of(q_idx), line_start: q_data.value,
									rel_offset: '0, status: ST_OK};
							end
						end
						K_SEARCH: begin
							q_pop    = 1'b1;
							lo_d     = '0;
							hi_d     = q_idx;
							lo_val_d = '0;
							rel_d    = q_data.value;
							mid_d    = mid_of('0, q_idx);
							if (q_idx != '0) begin
								rd_en  = 1'b1;
								pend_d = 1'b1;
							end
							st_d = B_SEARCH;
						end
						default: begin
							if (out_free) begin
								q_pop = 1'b1;
								load  = 1'b1;
								res_d = '{line_number: '0, line_start: '0, rel_offset: '0,
									status: q_data.status};
							end
						end
					endcase
				end
			end
			B_SEARCH: begin
				lo_d     = s_lo;
				hi_d     = s_hi;
				lo_val_d = s_lo_val;
				if (s_lo < s_hi) begin
					mid_d  = mid_of(s_lo, s_hi);
					rd_en  = 1'b1;
					pend_d = 1'b1;
				end else if (out_free) begin
					load  = 1'b1;
					res_d = '{line_number: line_of(s_lo), line_start: s_lo_val,
						rel_offset: rel_q, status: ST_OK};
					st_d  = B_IDLE;
				end
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[q_idx] <= q_data.value;
		end
		if (rd_en) begin
			rd_data_q <= mem[mid_d];
		end
	end

	always_ff @(posedge clk) begin
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		lo_val_q <= lo_val_d;
		rel_q    <= rel_d;
		mid_q    <= mid_d;
		if (load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= B_IDLE;
			pend_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			st_q     <= st_d;
			pend_q   <= pend_d;
			ovalid_q <= load || (ovalid_q && !out_ready);
		end
	end

endmodule

@@ rtl/core/offset_to_line_lookup_unit.sv @@
// offset to line lookup unit, top level
// depends on oll_pkg, oll_front, oll_queue, oll_back and the assertion macro header
//
// usage:
//   input channel (in_valid/in_ready, cmd, offset): cmd 0 appends a relative line start,
//   cmd 1 looks up a global offset. output channel (out_valid/out_ready) gives one result
//   per input transfer: line_number, line_start, rel_offset and status.
//   cfg_we/cfg_wdata write the base_offset register; write it only while idle.
//   the front end checks each item on accept (table full, non-ascending append, offset
//   below base) and pushes it into a two entry queue, so it keeps taking input while the
//   back end searches or the receiver stalls.
//   path: an accepted transfer is registered into the queue; the back end pops it and
//   loads the output register for an append or error, while a lookup first runs its
//   binary search and then loads the output register.
//   the back end handles one queued item at a time and pops no new one while a lookup
//   searches; the single read port of the line start memory allows one read per
//   halving step.
//   reset: the table holds line 1 at offset 0, base_offset is 0, queue and output are
//   empty; there is no clearing pass.
//   a stalled receiver holds the result in the output register; the back end may still
//   search but holds the next result, and the front fills the queue, then drops in_ready.
`include "offset_to_line_lookup_unit_macros.svh"

module offset_to_line_lookup_unit #(
	parameter int unsigned MAX_LINES = oll_pkg::OLL_MAX_LINES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  logic [oll_pkg::OFS_W-1:0] offset,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [oll_pkg::LN_W-1:0]  line_number,
	output logic [oll_pkg::OFS_W-1:0] line_start,
	output logic [oll_pkg::OFS_W-1:0] rel_offset,
	output logic [1:0]                status,
	input  logic                      cfg_we,
	input  logic [oll_pkg::OFS_W-1:0] cfg_wdata
);
	import oll_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_LINES);

	// front to queue
	logic             q_push;
	op_t              q_in;
	logic [IDX_W-1:0] q_in_idx;
	logic             q_full;
	// queue to back
	logic             q_pop;
	logic             q_empty;
	op_t              q_out;
	logic [IDX_W-1:0] q_out_idx;

	// classify on accept, track line count and last start
	oll_front #(
		.MAX_LINES(MAX_LINES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.offset   (offset),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in),
		.q_idx    (q_in_idx)
	);

	// decouples front and back so each can stall alone
	oll_queue #(
		.IDX_W(IDX_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.data_in (q_in),
		.idx_in  (q_in_idx),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.data_out(q_out),
		.idx_out (q_out_idx)
	);

	// memory writes, binary search and the output register
	oll_back #(
		.MAX_LINES(MAX_LINES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_out),
		.q_idx      (q_out_idx),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.line_number(line_number),
		.line_start (line_start),
		.rel_offset (rel_offset),
		.status     (status)
	);

	// checks
	`OLL_ASSERT_SAME(a_no_push_full, clk, arst_n, q_push, !q_full, "push into full queue")
	`OLL_ASSERT_SAME(a_no_pop_empty, clk, arst_n, q_pop, !q_empty, "pop from empty queue")
	`OLL_ASSERT_NEXT(a_write_result, clk, arst_n, q_pop && (q_out.kind == K_WRITE),
		out_valid, "append popped without result")
	`OLL_ASSERT_SAME(a_error_zero, clk, arst_n, out_valid && (status != ST_OK),
		(line_number == '0) && (line_start == '0) && (rel_offset == '0),
		"error result with nonzero fields")

endmodule
